// File: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// First-fit bin allocator package
// Sizes, opcodes and helpers shared by the allocator and its channel interfaces.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BINS   = 1024;
  localparam int CAP_WIDTH  = 16;

  localparam int OP_W       = 2;
  localparam int BIN_W      = 10;
  localparam int FIELD_W    = 16;
  localparam int REQ_W      = 16;

  localparam int TREE_DEPTH = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NODE_W     = TREE_DEPTH + 1;
  localparam int TREE_SLOTS = 2 ** NODE_W;
  localparam int CMP_W      = (CAP_WIDTH > REQ_W) ? CAP_WIDTH : REQ_W;

  localparam logic [NODE_W-1:0] ROOT_NODE  = NODE_W'(1);
  localparam logic [REQ_W-1:0]  MISS_MAX   = '1;

  typedef logic [CAP_WIDTH-1:0] cap_t;
  typedef logic [NODE_W-1:0]    node_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_PLACE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  function automatic cap_t larger(input cap_t a, input cap_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: rtl/ffba_if.sv
// ----------------------------------------------------------------------------
// First-fit bin allocator channels
// Valid/ready channels for request beats and for result beats.
// ----------------------------------------------------------------------------
interface ffba_in_if
  import ffba_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [BIN_W-1:0]   bin_index;
  logic [FIELD_W-1:0] capacity;
  logic [REQ_W-1:0]   request_size;

  modport source (output valid, op, bin_index, capacity, request_size, input ready);
  modport sink   (input valid, op, bin_index, capacity, request_size, output ready);
endinterface

interface ffba_out_if
  import ffba_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             placed;
  logic [BIN_W-1:0] chosen_bin;
  logic [REQ_W-1:0] miss_total;

  modport source (output valid, placed, chosen_bin, miss_total, input ready);
  modport sink   (input valid, placed, chosen_bin, miss_total, output ready);
endinterface

// File: rtl/first_fit_bin_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit bin allocator
// Max segment tree in one synchronous memory; finds the leftmost bin that fits.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  in_i     sink       op, bin_index, capacity, request_size
//  out_o    source     placed, chosen_bin, miss_total (one per place beat)
//
//  A place beat runs from its accept to the next through these steps, in order:
//  root read, check, one step per level down, leaf write, one per level up, hand-off.
//  A miss goes from the check straight to hand-off; a load runs leaf write, then up to the root.
//  Reset and clear sweep all TREE_SLOTS (2048) words, one word a cycle, with ready low.
//  A waiting result stalls the next place beat only when its own result is ready.
// ----------------------------------------------------------------------------
module first_fit_bin_allocator_unit
  import ffba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ffba_in_if.sink     in_i,
  ffba_out_if.source  out_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_DESC   = 8'b0000_1000,
    S_LEAF   = 8'b0001_0000,
    S_UP     = 8'b0010_0000,
    S_RESULT = 8'b0100_0000
  } state_e;

  state_e           state_q, state_d;
  node_t            clr_q, clr_d;
  logic [REQ_W-1:0] miss_q, miss_d;
  logic             is_place_q, is_place_d;
  logic             out_valid_q, out_valid_d;

  node_t            node_q, node_d;
  cap_t             val_q, val_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic             placed_q, placed_d;
  logic [BIN_W-1:0] chosen_q, chosen_d;
  logic             out_placed_q;
  logic [BIN_W-1:0] out_chosen_q;
  logic [REQ_W-1:0] out_miss_q;
  logic             out_load;

  cap_t             tree_mem [TREE_SLOTS];
  cap_t             rd_data_q;
  node_t            rd_addr;
  node_t            wr_addr;
  cap_t             wr_data;
  logic             mem_we;

  node_t            child_l;
  node_t            child_sel;
  node_t            parent;
  cap_t             up_max;
  logic             left_fits;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= tree_mem[rd_addr];
  end

  assign child_l   = {node_q[NODE_W-2:0], 1'b0};
  assign left_fits = CMP_W'(rd_data_q) >= CMP_W'(req_q);
  assign child_sel = left_fits ? child_l : (child_l | NODE_W'(1));
  assign parent    = node_q >> 1;
  assign up_max    = larger(val_q, rd_data_q);

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    miss_d      = miss_q;
    is_place_d  = is_place_q;
    node_d      = node_q;
    val_d       = val_q;
    req_d       = req_q;
    placed_d    = placed_q;
    chosen_d    = chosen_q;
    rd_addr     = ROOT_NODE;
    wr_addr     = node_q;
    wr_data     = val_q;
    mem_we      = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + NODE_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          case (op_e'(in_i.op))
            OP_LOAD: begin
              if (32'(in_i.bin_index) < NUM_BINS) begin
                node_d     = {1'b1, TREE_DEPTH'(in_i.bin_index)};
                val_d      = cap_t'(in_i.capacity);
                is_place_d = 1'b0;
                state_d    = S_LEAF;
              end
            end
            OP_PLACE: begin
              req_d      = (in_i.request_size == '0) ? REQ_W'(1) : in_i.request_size;
              is_place_d = 1'b1;
              state_d    = S_CHECK;
            end
            OP_CLEAR: begin
              miss_d  = '0;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (!left_fits) begin
          if (miss_q != MISS_MAX) begin
            miss_d = miss_q + REQ_W'(1);
          end
          placed_d = 1'b0;
          chosen_d = '0;
          state_d  = S_RESULT;
        end else begin
          node_d  = ROOT_NODE;
          rd_addr = {ROOT_NODE[NODE_W-2:0], 1'b0};
          state_d = S_DESC;
        end
      end
      S_DESC: begin
        node_d = child_sel;
        if (child_sel[TREE_DEPTH]) begin
          val_d   = '0;
          state_d = S_LEAF;
        end else begin
          rd_addr = {child_sel[NODE_W-2:0], 1'b0};
        end
      end
      S_LEAF: begin
        mem_we  = 1'b1;
        rd_addr = node_q ^ NODE_W'(1);
        if (is_place_q) begin
          placed_d = 1'b1;
          chosen_d = BIN_W'(node_q[TREE_DEPTH-1:0]);
        end
        state_d = S_UP;
      end
      S_UP: begin
        mem_we  = 1'b1;
        wr_addr = parent;
        wr_data = up_max;
        node_d  = parent;
        val_d   = up_max;
        rd_addr = parent ^ NODE_W'(1);
        if (parent == ROOT_NODE) begin
          state_d = is_place_q ? S_RESULT : S_IDLE;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      miss_q      <= '0;
      is_place_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      miss_q      <= miss_d;
      is_place_q  <= is_place_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    val_q    <= val_d;
    req_q    <= req_d;
    placed_q <= placed_d;
    chosen_q <= chosen_d;
    if (out_load) begin
      out_placed_q <= placed_q;
      out_chosen_q <= chosen_q;
      out_miss_q   <= miss_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.placed     = out_placed_q;
  assign out_o.chosen_bin = out_chosen_q;
  assign out_o.miss_total = out_miss_q;

endmodule
